// File: rtl/core/sphere_collision_resolve_core_defines.svh
// ----------------------------------------------------------------------------
// sphere collision core assertion macros
// checks compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SPHERE_COLLISION_RESOLVE_CORE_DEFINES_SVH
`define SPHERE_COLLISION_RESOLVE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SCR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scr check failed");
// next-cycle implication
`define SCR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scr check failed");
`else
`define SCR_ASSERT_IMP(lbl, ante, cons)
`define SCR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: rtl/core/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg
// shared types and constants of the sphere collision core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scr_pkg;

  localparam int unsigned RESTIT_ONE   = 65536;
  localparam int unsigned RESTIT_SHIFT = 16;

  localparam logic FUNC_BODY     = 1'b0;
  localparam logic FUNC_PARTICLE = 1'b1;

  // register index as seen on paddr[2]
  localparam logic REG_BODY_COUNT  = 1'b0;
  localparam logic REG_RESTITUTION = 1'b1;

  typedef struct packed {
    logic               func;
    logic [2:0]         slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [30:0]        radius;
  } scr_in_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic signed [31:0] new_vx;
    logic signed [31:0] new_vy;
    logic signed [31:0] new_vz;
    logic               hit;
  } scr_out_t;

  // particle in flight, element 0 is x
  typedef struct packed {
    logic             vld;
    logic             hit;
    logic [2:0][31:0] p;
    logic [2:0][31:0] v;
  } scr_item_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] val);
    logic [31:0] res;
    if (val > 64'sd2147483647) begin
      res = 32'h7fff_ffff;
    end else if (val < -64'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = val[31:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/scr_body_sect.sv
// ----------------------------------------------------------------------------
// scr_body_sect
// pipeline section resolving one particle against one body slot
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scr_body_sect
  import scr_pkg::*;
#(
  parameter int unsigned IDX       = 0,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [3:0]       body_count,
  input  logic [17:0]      rest_gain,
  input  logic [2:0][31:0] body_c,
  input  logic [30:0]      body_rad,
  input  scr_item_t        item_i,
  output scr_item_t        item_o
);

  localparam int unsigned QW   = FRAC_BITS + 1;
  localparam int unsigned NW   = FRAC_BITS + 2;
  localparam int unsigned PW   = 32 + NW;
  localparam int unsigned DW   = PW + 2;
  localparam int unsigned VNW  = DW - FRAC_BITS;
  localparam int unsigned KW   = VNW + 19 - RESTIT_SHIFT;
  localparam int unsigned KNW  = KW + NW;
  localparam int unsigned SQ_N = 32;
  localparam int unsigned DV_N = QW;

  logic act;
  assign act = 32'(body_count) > IDX;

  // difference, range check, squares and squared-distance compare
  scr_item_t          a1_it_r, a2_it_r, b_it_r, c1_it_r, c2_it_r;
  logic signed [32:0] a1_d_nxt [3];
  logic signed [32:0] a1_d_r   [3];
  logic               a2_hot_nxt, a2_hot_r;
  logic [2:0]         a2_neg_nxt, a2_neg_r;
  logic [2:0][30:0]   a2_m_nxt, a2_m_r;
  logic               b_hot_r, c1_hot_r, c2_hot_r, c2_hot_nxt;
  logic [2:0]         b_neg_r, c1_neg_r, c2_neg_r;
  logic [2:0][30:0]   b_m_r, c1_m_r, c2_m_r;
  logic [61:0]        b_sq_r [3];
  logic [61:0]        b_r2_r, c1_r2_r;
  logic [63:0]        c1_s_nxt, c1_s_r, c2_s_r;

  always_comb begin
    logic [32:0] mg;
    a2_hot_nxt = act;
    for (int j = 0; j < 3; j++) begin
      a1_d_nxt[j] = 33'($signed(item_i.p[j])) - 33'($signed(body_c[j]));
      mg = a1_d_r[j][32] ? 33'(-a1_d_r[j]) : 33'(a1_d_r[j]);
      a2_neg_nxt[j] = a1_d_r[j][32];
      a2_m_nxt[j]   = mg[30:0];
      if (mg >= {2'b00, body_rad}) begin
        a2_hot_nxt = 1'b0;
      end
    end
    c1_s_nxt = 64'(b_sq_r[0]) + 64'(b_sq_r[1]) + 64'(b_sq_r[2]);
    c2_hot_nxt = c1_hot_r && (c1_s_r != 64'd0) && (c1_s_r < 64'(c1_r2_r));
  end

  // square root, one result bit per stage
  scr_item_t        sq_it_r  [SQ_N];
  logic             sq_hot_r [SQ_N];
  logic [2:0]       sq_neg_r [SQ_N];
  logic [2:0][30:0] sq_m_r   [SQ_N];
  logic [63:0]      sq_rem_r [SQ_N];
  logic [31:0]      sq_q_r   [SQ_N];

  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    localparam int unsigned BI = SQ_N - 1 - k;
    scr_item_t        it_in;
    logic             hot_in;
    logic [2:0]       neg_in;
    logic [2:0][30:0] m_in;
    logic [63:0]      rem_in, trial, rem_nxt;
    logic [31:0]      q_in, q_nxt;
    if (k == 0) begin : g_head
      assign it_in  = c2_it_r;
      assign hot_in = c2_hot_r;
      assign neg_in = c2_neg_r;
      assign m_in   = c2_m_r;
      assign rem_in = c2_s_r;
      assign q_in   = '0;
    end else begin : g_tail
      assign it_in  = sq_it_r[k-1];
      assign hot_in = sq_hot_r[k-1];
      assign neg_in = sq_neg_r[k-1];
      assign m_in   = sq_m_r[k-1];
      assign rem_in = sq_rem_r[k-1];
      assign q_in   = sq_q_r[k-1];
    end
    always_comb begin
      trial = ({32'd0, q_in} << (BI + 1)) | (64'd1 << (2 * BI));
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        q_nxt   = q_in | (32'd1 << BI);
      end else begin
        rem_nxt = rem_in;
        q_nxt   = q_in;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_it_r[k] <= '0;
      end else if (en) begin
        sq_it_r[k] <= it_in;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_hot_r[k] <= hot_in;
        sq_neg_r[k] <= neg_in;
        sq_m_r[k]   <= m_in;
        sq_rem_r[k] <= rem_nxt;
        sq_q_r[k]   <= q_nxt;
      end
    end
  end

  // normal components |d| * 2^F / dist, one quotient bit per stage
  scr_item_t        dv_it_r   [DV_N];
  logic             dv_hot_r  [DV_N];
  logic [2:0]       dv_neg_r  [DV_N];
  logic [30:0]      dv_dist_r [DV_N];
  logic [2:0][31:0] dv_rem_r  [DV_N];
  logic [2:0][QW-1:0] dv_q_r  [DV_N];

  for (genvar k = 0; k < DV_N; k++) begin : g_dv
    scr_item_t          it_in;
    logic               hot_in;
    logic [2:0]         neg_in;
    logic [30:0]        dist_in;
    logic [2:0][31:0]   rin, rem_nxt;
    logic [2:0][QW-1:0] q_in, q_nxt;
    if (k == 0) begin : g_head
      assign it_in   = sq_it_r[SQ_N-1];
      assign hot_in  = sq_hot_r[SQ_N-1];
      assign neg_in  = sq_neg_r[SQ_N-1];
      assign dist_in = sq_q_r[SQ_N-1][30:0];
      assign q_in    = '0;
      for (genvar j = 0; j < 3; j++) begin : g_ax
        assign rin[j] = {1'b0, sq_m_r[SQ_N-1][j]};
      end
    end else begin : g_tail
      assign it_in   = dv_it_r[k-1];
      assign hot_in  = dv_hot_r[k-1];
      assign neg_in  = dv_neg_r[k-1];
      assign dist_in = dv_dist_r[k-1];
      assign q_in    = dv_q_r[k-1];
      for (genvar j = 0; j < 3; j++) begin : g_ax
        assign rin[j] = {dv_rem_r[k-1][j][30:0], 1'b0};
      end
    end
    always_comb begin
      for (int j = 0; j < 3; j++) begin
        if (rin[j] >= {1'b0, dist_in}) begin
          rem_nxt[j] = rin[j] - {1'b0, dist_in};
          q_nxt[j]   = {q_in[j][QW-2:0], 1'b1};
        end else begin
          rem_nxt[j] = rin[j];
          q_nxt[j]   = {q_in[j][QW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_it_r[k] <= '0;
      end else if (en) begin
        dv_it_r[k] <= it_in;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_hot_r[k]  <= hot_in;
        dv_neg_r[k]  <= neg_in;
        dv_dist_r[k] <= dist_in;
        dv_rem_r[k]  <= rem_nxt;
        dv_q_r[k]    <= q_nxt;
      end
    end
  end

  // push to surface and velocity reflection
  scr_item_t             n_it_r, p1_it_r, p2_it_r, p3_it_r, p4_it_r, p5_it_r;
  logic                  n_hot_r, p1_hot_r, p2_hot_r, p3_hot_r, p4_hot_r;
  logic signed [NW-1:0]  n_n_nxt  [3];
  logic signed [NW-1:0]  n_n_r    [3];
  logic signed [NW-1:0]  p1_n_r   [3];
  logic signed [NW-1:0]  p2_n_r   [3];
  logic signed [NW-1:0]  p3_n_r   [3];
  logic signed [PW-1:0]  p1_rp_nxt [3];
  logic signed [PW-1:0]  p1_rp_r   [3];
  logic signed [PW-1:0]  p1_vn_nxt [3];
  logic signed [PW-1:0]  p1_vn_r   [3];
  logic [2:0][31:0]      p2_np_nxt, p2_np_r, p3_np_r, p4_np_r;
  logic signed [DW-1:0]  dot;
  logic signed [VNW-1:0] p2_vn_nxt, p2_vn_r;
  logic signed [VNW+18:0] kprod;
  logic signed [KW-1:0]  p3_k_nxt, p3_k_r;
  logic                  p3_dn_r, p4_dn_r;
  logic signed [KNW-1:0] p4_kn_nxt [3];
  logic signed [KNW-1:0] p4_kn_r   [3];
  scr_item_t             p5_it_nxt;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      n_n_nxt[j] = dv_neg_r[DV_N-1][j] ? -$signed({1'b0, dv_q_r[DV_N-1][j]})
                                       : $signed({1'b0, dv_q_r[DV_N-1][j]});
      p1_rp_nxt[j] = $signed({1'b0, body_rad}) * n_n_r[j];
      p1_vn_nxt[j] = $signed(n_it_r.v[j]) * n_n_r[j];
      p2_np_nxt[j] = sat32(64'($signed(body_c[j])) + 64'(p1_rp_r[j] >>> FRAC_BITS));
      p4_kn_nxt[j] = p3_k_r * p3_n_r[j];
    end
    dot       = DW'(p1_vn_r[0]) + DW'(p1_vn_r[1]) + DW'(p1_vn_r[2]);
    p2_vn_nxt = VNW'(dot >>> FRAC_BITS);
    kprod     = p2_vn_r * $signed({1'b0, rest_gain});
    p3_k_nxt  = KW'(kprod >>> RESTIT_SHIFT);
    p5_it_nxt = p4_it_r;
    if (p4_hot_r) begin
      p5_it_nxt.hit = 1'b1;
      p5_it_nxt.p   = p4_np_r;
      if (p4_dn_r) begin
        for (int j = 0; j < 3; j++) begin
          p5_it_nxt.v[j] = sat32(64'($signed(p4_it_r.v[j]))
                                 - 64'(p4_kn_r[j] >>> FRAC_BITS));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_it_r <= '0;
      a2_it_r <= '0;
      b_it_r  <= '0;
      c1_it_r <= '0;
      c2_it_r <= '0;
      n_it_r  <= '0;
      p1_it_r <= '0;
      p2_it_r <= '0;
      p3_it_r <= '0;
      p4_it_r <= '0;
      p5_it_r <= '0;
    end else if (en) begin
      a1_it_r <= item_i;
      a2_it_r <= a1_it_r;
      b_it_r  <= a2_it_r;
      c1_it_r <= b_it_r;
      c2_it_r <= c1_it_r;
      n_it_r  <= dv_it_r[DV_N-1];
      p1_it_r <= n_it_r;
      p2_it_r <= p1_it_r;
      p3_it_r <= p2_it_r;
      p4_it_r <= p3_it_r;
      p5_it_r <= p5_it_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        a1_d_r[j]  <= a1_d_nxt[j];
        b_sq_r[j]  <= 62'(a2_m_r[j]) * 62'(a2_m_r[j]);
        n_n_r[j]   <= n_n_nxt[j];
        p1_n_r[j]  <= n_n_r[j];
        p2_n_r[j]  <= p1_n_r[j];
        p3_n_r[j]  <= p2_n_r[j];
        p1_rp_r[j] <= p1_rp_nxt[j];
        p1_vn_r[j] <= p1_vn_nxt[j];
        p4_kn_r[j] <= p4_kn_nxt[j];
      end
      a2_hot_r <= a2_hot_nxt;
      a2_neg_r <= a2_neg_nxt;
      a2_m_r   <= a2_m_nxt;
      b_hot_r  <= a2_hot_r;
      b_neg_r  <= a2_neg_r;
      b_m_r    <= a2_m_r;
      b_r2_r   <= 62'(body_rad) * 62'(body_rad);
      c1_hot_r <= b_hot_r;
      c1_neg_r <= b_neg_r;
      c1_m_r   <= b_m_r;
      c1_r2_r  <= b_r2_r;
      c1_s_r   <= c1_s_nxt;
      c2_hot_r <= c2_hot_nxt;
      c2_neg_r <= c1_neg_r;
      c2_m_r   <= c1_m_r;
      c2_s_r   <= c1_s_r;
      n_hot_r  <= dv_hot_r[DV_N-1];
      p1_hot_r <= n_hot_r;
      p2_hot_r <= p1_hot_r;
      p2_np_r  <= p2_np_nxt;
      p2_vn_r  <= p2_vn_nxt;
      p3_hot_r <= p2_hot_r;
      p3_np_r  <= p2_np_r;
      p3_k_r   <= p3_k_nxt;
      p3_dn_r  <= p2_vn_r[VNW-1];
      p4_hot_r <= p3_hot_r;
      p4_np_r  <= p3_np_r;
      p4_dn_r  <= p3_dn_r;
    end
  end

  assign item_o = p5_it_r;

endmodule

`default_nettype wire

// File: rtl/core/sphere_collision_resolve_core.sv
// ----------------------------------------------------------------------------
// sphere_collision_resolve_core
// Resolves particles against up to MAX_BODIES spheres held in a body table.
// One particle word enters per cycle while the result is not stalled; each
// body slot owns a pipeline section whose length is set by the 32-step
// square root and the (FRAC_BITS + 1)-step normal divider. A body-load word
// is taken only once every particle in flight has been delivered, then
// updates its body slot and produces no result. A stalled result holds the
// whole pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sphere_collision_resolve_core_defines.svh"

module sphere_collision_resolve_core
  import scr_pkg::*;
#(
  parameter int unsigned MAX_BODIES = 8,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  scr_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output scr_out_t    out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned SECT_LAT   = 44 + FRAC_BITS;
  localparam int unsigned PIPE_DEPTH = MAX_BODIES * SECT_LAT + 1;
  localparam int unsigned CNT_W      = $clog2(PIPE_DEPTH + 1);
  localparam int unsigned IDX_W      = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;

  logic [3:0]       body_count_r;
  logic [16:0]      restit_r;
  logic [17:0]      gain_nxt, gain_r;
  logic [2:0][31:0] body_c_r   [MAX_BODIES];
  logic [30:0]      body_rad_r [MAX_BODIES];
  logic             out_valid_r;
  scr_out_t         out_data_r;
  logic [CNT_W-1:0] inflight_nxt, inflight_r;
  logic             adv, in_acc, out_acc, cfg_wr;
  scr_item_t        chain [MAX_BODIES+1];

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_paddr[2])
      REG_BODY_COUNT:  cfg_prdata = {28'd0, body_count_r};
      REG_RESTITUTION: cfg_prdata = {15'd0, restit_r};
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_count_r <= '0;
      restit_r     <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_BODY_COUNT:  body_count_r <= cfg_pwdata[3:0];
        REG_RESTITUTION: restit_r     <= cfg_pwdata[16:0];
        default:         ;
      endcase
    end
  end

  // reflection gain 1 + e in Q2.16, e clamped to one
  assign gain_nxt = 18'(RESTIT_ONE) + ((restit_r > 17'(RESTIT_ONE)) ? 18'(RESTIT_ONE)
                                                                     : {1'b0, restit_r});
  always_ff @(posedge clk) begin
    gain_r <= gain_nxt;
  end

  // handshake; body loads wait for an empty pipeline
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && ((in_data.func == FUNC_PARTICLE) || (inflight_r == '0));
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (in_acc && (in_data.func == FUNC_BODY) && (32'(in_data.slot) < MAX_BODIES)) begin
      body_c_r[IDX_W'(in_data.slot)]   <= {in_data.pos_z, in_data.pos_y, in_data.pos_x};
      body_rad_r[IDX_W'(in_data.slot)] <= in_data.radius;
    end
  end

  assign inflight_nxt = inflight_r
                        + CNT_W'(in_acc && (in_data.func == FUNC_PARTICLE))
                        - CNT_W'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  always_comb begin
    chain[0].vld  = in_acc && (in_data.func == FUNC_PARTICLE);
    chain[0].hit  = 1'b0;
    chain[0].p    = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
    chain[0].v    = {in_data.vel_z, in_data.vel_y, in_data.vel_x};
  end

  for (genvar i = 0; i < MAX_BODIES; i++) begin : g_sect
    scr_body_sect #(
      .IDX       (i),
      .FRAC_BITS (FRAC_BITS)
    ) u_sect (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (adv),
      .body_count (body_count_r),
      .rest_gain  (gain_r),
      .body_c     (body_c_r[i]),
      .body_rad   (body_rad_r[i]),
      .item_i     (chain[i]),
      .item_o     (chain[i+1])
    );
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain[MAX_BODIES].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.new_x  <= chain[MAX_BODIES].p[0];
      out_data_r.new_y  <= chain[MAX_BODIES].p[1];
      out_data_r.new_z  <= chain[MAX_BODIES].p[2];
      out_data_r.new_vx <= chain[MAX_BODIES].v[0];
      out_data_r.new_vy <= chain[MAX_BODIES].v[1];
      out_data_r.new_vz <= chain[MAX_BODIES].v[2];
      out_data_r.hit    <= chain[MAX_BODIES].hit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SCR_ASSERT_IMP(a_out_counted, out_valid_r, inflight_r != '0)
  `SCR_ASSERT_IMP(a_inflight_bound, 1'b1, inflight_r <= CNT_W'(PIPE_DEPTH))
  `SCR_ASSERT_IMP(a_no_bodies_no_hit, out_valid_r && (body_count_r == 4'd0), !out_data_r.hit)
  `SCR_ASSERT_NXT(a_drain_count, out_acc && !in_acc, inflight_r == $past(inflight_r) - 1'b1)

endmodule

`default_nettype wire
